>>> rtl/kwcc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Keyboard wedge code capture package
// Shared widths, codes and controller/datapath interface types.
// ----------------------------------------------------------------------------
package kwcc_pkg;

   localparam int KEY_W      = 17;
   localparam int TIME_W     = 32;
   localparam int GAP_W      = 16;
   localparam int KIND_W     = 2;
   localparam int BYTE_W     = 8;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 17;

   localparam logic REQ_KEY  = 1'b0;
   localparam logic REQ_READ = 1'b1;

   localparam logic [KIND_W-1:0] KIND_KEY  = 2'd0;
   localparam logic [KIND_W-1:0] KIND_BYTE = 2'd1;
   localparam logic [KIND_W-1:0] KIND_NONE = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_WEDGE_ENABLE  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PREFIX_KEY    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SUFFIX_KEY    = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_KEYBOARD_KIND = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_GAP_TIMEOUT   = 3'd4;

   localparam logic [KEY_W-1:0] IDLE_CODE_PC  = 17'h1FC19;
   localparam logic [KEY_W-1:0] IDLE_CODE_KB  = 17'h0F000;
   localparam logic [KEY_W-1:0] PREFIX_RESET  = 17'd0;
   localparam logic [KEY_W-1:0] SUFFIX_RESET  = 17'd13;
   localparam logic [GAP_W-1:0] GAP_RESET     = 16'd36;

   typedef struct packed {
      logic take_single;
      logic rd_start;
      logic send_byte;
   } kwcc_cmd_type;

   typedef struct packed {
      logic out_free;
      logic code_avail;
      logic rd_last;
   } kwcc_status_type;

endpackage
`default_nettype wire

>>> rtl/kwcc_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Keyboard wedge code capture controller
// Sequences single-result requests and the byte stream of a code read.
// ----------------------------------------------------------------------------
module kwcc_ctrl
   import kwcc_pkg::*;
(
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            req_tvalid,
   output logic                 req_tready,
   input  wire logic            req_tuser,
   input  wire kwcc_status_type status,
   output kwcc_cmd_type         cmd
);

   typedef enum logic [2:0] {
      ST_IDLE  = 3'b001,
      ST_FETCH = 3'b010,
      ST_SEND  = 3'b100
   } kwcc_state_type;

   kwcc_state_type state_ff, state_in;

   always_comb begin
      state_in        = state_ff;
      req_tready      = 1'b0;
      cmd.take_single = 1'b0;
      cmd.rd_start    = 1'b0;
      cmd.send_byte   = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_tready = status.out_free;
            if (req_tvalid && status.out_free) begin
               if (req_tuser == REQ_READ && status.code_avail) begin
                  cmd.rd_start = 1'b1;
                  state_in     = ST_FETCH;
               end else begin
                  cmd.take_single = 1'b1;
               end
            end
         end
         ST_FETCH: begin
            state_in = ST_SEND;
         end
         ST_SEND: begin
            if (status.out_free) begin
               cmd.send_byte = 1'b1;
               if (status.rd_last) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule
`default_nettype wire

>>> rtl/kwcc_datapath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Keyboard wedge code capture datapath
// Configuration, capture state, code memory and the result register.
// ----------------------------------------------------------------------------
module kwcc_datapath
   import kwcc_pkg::*;
#(
   parameter int CODE_DEPTH = 64
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  csr_write,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_data,
   input  wire logic                  req_type,
   input  wire logic [KEY_W-1:0]      key_code,
   input  wire logic [TIME_W-1:0]     time_now,
   input  wire kwcc_cmd_type          cmd,
   output kwcc_status_type            status,
   input  wire logic                  rsp_tready,
   output logic                       rsp_tvalid,
   output logic [KIND_W-1:0]          rsp_kind,
   output logic [KEY_W-1:0]           rsp_value,
   output logic                       rsp_last
);

   localparam int AW = (CODE_DEPTH > 1) ? $clog2(CODE_DEPTH) : 1;
   localparam int FW = $clog2(CODE_DEPTH + 1);

   logic              enable_ff;
   logic [KEY_W-1:0]  prefix_ff;
   logic [KEY_W-1:0]  suffix_ff;
   logic              kb_kind_ff;
   logic [GAP_W-1:0]  gap_ff;

   logic              capturing_ff, capturing_in;
   logic              code_ready_ff, code_ready_in;
   logic [FW-1:0]     fill_ff, fill_in;
   logic [TIME_W-1:0] last_time_ff, last_time_in;
   logic [AW-1:0]     idx_ff, idx_in;

   logic              rsp_valid_ff, rsp_valid_in;
   logic [KIND_W-1:0] rsp_kind_ff, rsp_kind_in;
   logic [KEY_W-1:0]  rsp_value_ff, rsp_value_in;
   logic              rsp_last_ff, rsp_last_in;

   logic [BYTE_W-1:0] mem [CODE_DEPTH];
   logic [BYTE_W-1:0] rd_data_ff;
   logic [AW-1:0]     rd_addr;
   logic              mem_we;

   logic [KEY_W-1:0]  idle_code;
   logic [TIME_W-1:0] gap_elapsed;
   logic              gap_over;
   logic              store_room;
   logic [KEY_W-1:0]  ret_code;

   assign idle_code   = kb_kind_ff ? IDLE_CODE_PC : IDLE_CODE_KB;
   assign gap_elapsed = time_now - last_time_ff;
   assign gap_over    = gap_elapsed > {{(TIME_W-GAP_W){1'b0}}, gap_ff};
   assign store_room  = fill_ff < FW'(CODE_DEPTH);

   assign status.out_free   = !rsp_valid_ff || rsp_tready;
   assign status.code_avail = enable_ff && code_ready_ff && (fill_ff != '0);
   assign status.rd_last    = (FW'(idx_ff) + FW'(1)) == fill_ff;

   assign rd_addr = (cmd.send_byte && !status.rd_last) ? idx_ff + AW'(1) : idx_ff;

   always_comb begin
      capturing_in  = capturing_ff;
      code_ready_in = code_ready_ff;
      fill_in       = fill_ff;
      last_time_in  = last_time_ff;
      idx_in        = idx_ff;
      mem_we        = 1'b0;
      ret_code      = idle_code;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_kind_in   = rsp_kind_ff;
      rsp_value_in  = rsp_value_ff;
      rsp_last_in   = rsp_last_ff;

      if (cmd.take_single) begin
         rsp_valid_in = 1'b1;
         rsp_last_in  = 1'b1;
         rsp_kind_in  = KIND_KEY;
         rsp_value_in = key_code;
         if (req_type == REQ_READ) begin
            rsp_kind_in  = KIND_NONE;
            rsp_value_in = '0;
            if (enable_ff && code_ready_ff) begin
               code_ready_in = 1'b0;
            end
         end else if (enable_ff) begin
            if (capturing_ff) begin
               if (key_code == idle_code) begin
                  if (gap_over) begin
                     if (fill_ff == '0) begin
                        ret_code = prefix_ff;
                     end
                     capturing_in = 1'b0;
                  end
               end else if (key_code == suffix_ff) begin
                  capturing_in  = 1'b0;
                  code_ready_in = 1'b1;
               end else if (store_room) begin
                  mem_we  = 1'b1;
                  fill_in = fill_ff + FW'(1);
               end else begin
                  capturing_in = 1'b0;
               end
               last_time_in = time_now;
               rsp_value_in = ret_code;
            end else if (key_code == prefix_ff) begin
               capturing_in = 1'b1;
               last_time_in = time_now;
               fill_in      = '0;
               rsp_value_in = idle_code;
            end
         end
      end

      if (cmd.rd_start) begin
         code_ready_in = 1'b0;
         idx_in        = '0;
      end

      if (cmd.send_byte) begin
         rsp_valid_in = 1'b1;
         rsp_kind_in  = KIND_BYTE;
         rsp_value_in = {{(KEY_W-BYTE_W){1'b0}}, rd_data_ff};
         rsp_last_in  = status.rd_last;
         if (!status.rd_last) begin
            idx_in = idx_ff + AW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff     <= 1'b0;
         prefix_ff     <= PREFIX_RESET;
         suffix_ff     <= SUFFIX_RESET;
         kb_kind_ff    <= 1'b0;
         gap_ff        <= GAP_RESET;
         capturing_ff  <= 1'b0;
         code_ready_ff <= 1'b0;
         fill_ff       <= '0;
         last_time_ff  <= '0;
         idx_ff        <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (csr_write) begin
            case (csr_index)
               CSR_WEDGE_ENABLE:  enable_ff  <= csr_data[0];
               CSR_PREFIX_KEY:    prefix_ff  <= csr_data;
               CSR_SUFFIX_KEY:    suffix_ff  <= csr_data;
               CSR_KEYBOARD_KIND: kb_kind_ff <= csr_data[0];
               CSR_GAP_TIMEOUT:   gap_ff     <= csr_data[GAP_W-1:0];
               default: begin
               end
            endcase
         end
         capturing_ff  <= capturing_in;
         code_ready_ff <= code_ready_in;
         fill_ff       <= fill_in;
         last_time_ff  <= last_time_in;
         idx_ff        <= idx_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_kind_ff  <= rsp_kind_in;
      rsp_value_ff <= rsp_value_in;
      rsp_last_ff  <= rsp_last_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[fill_ff[AW-1:0]] <= key_code[BYTE_W-1:0];
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_kind   = rsp_kind_ff;
   assign rsp_value  = rsp_value_ff;
   assign rsp_last   = rsp_last_ff;

`ifndef SYNTH
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= FW'(CODE_DEPTH))
      else $error("fill count exceeds code depth");

   a_load_when_free: assert property (@(posedge clock) disable iff (reset)
      (cmd.take_single || cmd.send_byte) |-> status.out_free)
      else $error("result register overwritten while stalled");

   a_read_consumes: assert property (@(posedge clock) disable iff (reset)
      cmd.rd_start |=> !code_ready_ff)
      else $error("code still marked ready after read start");

   a_one_command: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.take_single, cmd.rd_start, cmd.send_byte}))
      else $error("more than one datapath command at once");
`endif

endmodule
`default_nettype wire

>>> rtl/keyboard_wedge_code_capture.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Keyboard wedge code capture
// Separates scanner codes from a keyboard key stream and reads them back.
// ----------------------------------------------------------------------------
// Requests arrive on req_*: tuser 0 is a key event, 1 reads the stored code.
// A key event yields one registered result: the key itself, the idle key
// code while a scan is swallowed, or the prefix key when a timeout ends an
// empty scan. A read yields one "no code" result, or the stored bytes after a
// memory fetch, one per cycle while the receiver takes them, with tlast on
// the final byte. Key events run at one per cycle while the receiver keeps up.
// Results sit in a single output register; when the receiver stalls the
// register holds and no new request is taken until it frees up.
// Configuration is to be written on csr_* only while no request is in
// progress; the block itself does not enforce this. Reset restores the
// register defaults and clears capture state and the ready flag; the code
// memory is not cleared and needs no clearing pass.
// ----------------------------------------------------------------------------
module keyboard_wedge_code_capture
   import kwcc_pkg::*;
#(
   parameter int CODE_DEPTH = 64
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  csr_valid,
   output logic                       csr_ready,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_data,
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   input  wire logic [55:0]           req_tdata,  // key_code[16:0], time_now[48:17]
   input  wire logic                  req_tuser,  // req_type
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   output logic [23:0]                rsp_tdata,  // out_value[16:0]
   output logic [KIND_W-1:0]          rsp_tuser,  // out_kind[1:0]
   output logic                       rsp_tlast   // out_last
);

   kwcc_cmd_type    cmd;
   kwcc_status_type status;
   logic [KEY_W-1:0] rsp_value;

   assign csr_ready = 1'b1;

   kwcc_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .status     (status),
      .cmd        (cmd)
   );

   kwcc_datapath #(
      .CODE_DEPTH (CODE_DEPTH)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .csr_write  (csr_valid),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .req_type   (req_tuser),
      .key_code   (req_tdata[KEY_W-1:0]),
      .time_now   (req_tdata[KEY_W+TIME_W-1:KEY_W]),
      .cmd        (cmd),
      .status     (status),
      .rsp_tready (rsp_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_kind   (rsp_tuser),
      .rsp_value  (rsp_value),
      .rsp_last   (rsp_tlast)
   );

   assign rsp_tdata = {{(24-KEY_W){1'b0}}, rsp_value};

endmodule
`default_nettype wire
